// File: design/quaternion_vector_rotate_assert.svh
// Assertion macros for the quaternion vector rotation block
`ifndef QUATERNION_VECTOR_ROTATE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define QVR_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error("qvr implication check failed");

// Next-cycle implication, disabled during reset
`define QVR_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("qvr next-cycle check failed");

// Next-cycle implication that also watches the reset itself
`define QVR_ASSERT_RST(lbl, a, b) \
    lbl: assert property (@(posedge aclk) (a) |=> (b)) \
        else $error("qvr reset check failed");

`endif

// File: design/qvr_pkg.sv
// Shared constants and types for the quaternion vector rotation block
`default_nettype none
package qvr_pkg;
    // Small-scalar threshold: 1e10*aa < 49999041*n2 rewritten as
    // aa*(1e10 - 49999041) < 49999041*(bb + cc + dd)
    localparam logic [33:0] THR_A = 34'd9950000959;
    localparam logic [25:0] THR_B = 26'd49999041;

    // Per-lane control carried down the divider chain
    typedef struct packed {
        logic neg;
        logic sat;
    } qvr_ctl_t;
endpackage
`default_nettype wire

// File: design/qvr_front.sv
// Front pipeline: products, matrix rows, threshold test and divider operands
`default_nettype none
module qvr_front #(
    parameter int W = 16
) (
    input  wire                          aclk,
    input  wire  [4:0]                   en,
    input  wire  signed [W-1:0]          quat_w,
    input  wire  signed [W-1:0]          quat_i,
    input  wire  signed [W-1:0]          quat_j,
    input  wire  signed [W-1:0]          quat_k,
    input  wire  signed [W-1:0]          vec_x,
    input  wire  signed [W-1:0]          vec_y,
    input  wire  signed [W-1:0]          vec_z,
    output logic [2:0][3*W+6:0]          rem_o,
    output qvr_pkg::qvr_ctl_t [2:0]      ctl_o,
    output logic [2*W+1:0]               den_o,
    output logic                         pass_o,
    output logic [2:0][W-1:0]            vec_o
);
    localparam int PW  = 2 * W;
    localparam int NW  = 2 * W + 1;
    localparam int MW  = 2 * W + 3;
    localparam int PRW = MW + W;
    localparam int LW  = PRW + 2;
    localparam int RW  = 3 * W + 7;
    localparam int CW  = 2 * W + 35;

    // Stage 1: all pairwise products
    logic signed [PW-1:0] aa_reg, bb_reg, cc_reg, dd_reg;
    logic signed [PW-1:0] bc_reg, ad_reg, bd_reg, ac_reg, cd_reg, ab_reg;
    logic signed [W-1:0]  v1_reg [3];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            aa_reg <= quat_w * quat_w;
            bb_reg <= quat_i * quat_i;
            cc_reg <= quat_j * quat_j;
            dd_reg <= quat_k * quat_k;
            bc_reg <= quat_i * quat_j;
            ad_reg <= quat_w * quat_k;
            bd_reg <= quat_i * quat_k;
            ac_reg <= quat_w * quat_j;
            cd_reg <= quat_j * quat_k;
            ab_reg <= quat_w * quat_i;
            v1_reg[0] <= vec_x;
            v1_reg[1] <= vec_y;
            v1_reg[2] <= vec_z;
        end
    end

    // Stage 2: norm, partial norm and unnormalized matrix
    logic [NW-1:0]        n2_2_reg, bcd_reg;
    logic [PW-1:0]        aa2_reg;
    logic signed [MW-1:0] m_reg [9];
    logic signed [W-1:0]  v2_reg [3];

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            n2_2_reg <= NW'($unsigned(aa_reg)) + NW'($unsigned(bb_reg))
                      + NW'($unsigned(cc_reg)) + NW'($unsigned(dd_reg));
            bcd_reg  <= NW'($unsigned(bb_reg)) + NW'($unsigned(cc_reg))
                      + NW'($unsigned(dd_reg));
            aa2_reg  <= $unsigned(aa_reg);
            m_reg[0] <= MW'(aa_reg) + MW'(bb_reg) - MW'(cc_reg) - MW'(dd_reg);
            m_reg[1] <= (MW'(bc_reg) - MW'(ad_reg)) <<< 1;
            m_reg[2] <= (MW'(bd_reg) + MW'(ac_reg)) <<< 1;
            m_reg[3] <= (MW'(bc_reg) + MW'(ad_reg)) <<< 1;
            m_reg[4] <= MW'(aa_reg) - MW'(bb_reg) + MW'(cc_reg) - MW'(dd_reg);
            m_reg[5] <= (MW'(cd_reg) - MW'(ab_reg)) <<< 1;
            m_reg[6] <= (MW'(bd_reg) - MW'(ac_reg)) <<< 1;
            m_reg[7] <= (MW'(cd_reg) + MW'(ab_reg)) <<< 1;
            m_reg[8] <= MW'(aa_reg) - MW'(bb_reg) - MW'(cc_reg) + MW'(dd_reg);
            v2_reg   <= v1_reg;
        end
    end

    // Stage 3: threshold products and matrix-times-vector products
    logic [CW-1:0]         lhs_reg, rhs_reg;
    logic                  zero_reg;
    logic [NW-1:0]         n2_3_reg;
    logic signed [PRW-1:0] pr_reg [9];
    logic signed [W-1:0]   v3_reg [3];

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            lhs_reg  <= CW'(aa2_reg) * CW'(qvr_pkg::THR_A);
            rhs_reg  <= CW'(bcd_reg) * CW'(qvr_pkg::THR_B);
            zero_reg <= (n2_2_reg == '0);
            n2_3_reg <= n2_2_reg;
            for (int i = 0; i < 9; i++) begin
                pr_reg[i] <= PRW'(m_reg[i]) * PRW'(v2_reg[i % 3]);
            end
            v3_reg <= v2_reg;
        end
    end

    // Stage 4: row sums and pass-through decision
    logic signed [LW-1:0] row_reg [3];
    logic                 pass4_reg;
    logic [NW-1:0]        n2_4_reg;
    logic signed [W-1:0]  v4_reg [3];

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int r = 0; r < 3; r++) begin
                row_reg[r] <= LW'(pr_reg[3*r]) + LW'(pr_reg[3*r+1]) + LW'(pr_reg[3*r+2]);
            end
            pass4_reg <= zero_reg || (lhs_reg < rhs_reg);
            n2_4_reg  <= n2_3_reg;
            v4_reg    <= v3_reg;
        end
    end

    // Stage 5: rounding numerator, sign and overflow flag per lane
    logic [LW-1:0] mag [3];
    logic [RW-1:0] num [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            mag[r] = row_reg[r][LW-1] ? $unsigned(-row_reg[r]) : $unsigned(row_reg[r]);
            num[r] = {1'b0, mag[r], 1'b0} + RW'(n2_4_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int r = 0; r < 3; r++) begin
                rem_o[r]     <= num[r];
                ctl_o[r].neg <= row_reg[r][LW-1];
                ctl_o[r].sat <= num[r] >= (RW'(n2_4_reg) << (W + 1));
                vec_o[r]     <= v4_reg[r];
            end
            den_o  <= {n2_4_reg, 1'b0};
            pass_o <= pass4_reg;
        end
    end
endmodule
`default_nettype wire

// File: design/qvr_div_cell.sv
// One restoring-division cell: resolves one quotient bit and hands on
`default_nettype none
module qvr_div_cell #(
    parameter int W     = 16,
    parameter int SHIFT = 0
) (
    input  wire                       aclk,
    input  wire                       en,
    input  wire  [3*W+6:0]            rem_i,
    input  wire  [2*W+1:0]            den_i,
    input  wire  [W-1:0]              quo_i,
    input  qvr_pkg::qvr_ctl_t         ctl_i,
    output logic [3*W+6:0]            rem_o,
    output logic [2*W+1:0]            den_o,
    output logic [W-1:0]              quo_o,
    output qvr_pkg::qvr_ctl_t         ctl_o
);
    localparam int RW = 3 * W + 7;

    logic [RW:0]   diff;
    logic          ge;
    logic [W-1:0]  quo_next;
    logic [RW-1:0] rem_next;

    // Trial subtract of the shifted divisor
    always_comb begin
        diff     = {1'b0, rem_i} - {1'b0, RW'(den_i) << SHIFT};
        ge       = !diff[RW];
        rem_next = ge ? diff[RW-1:0] : rem_i;
        quo_next = quo_i;
        quo_next[SHIFT] = ge;
    end

    // Advance to the next cell
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_o <= rem_next;
            den_o <= den_i;
            quo_o <= quo_next;
            ctl_o <= ctl_i;
        end
    end
endmodule
`default_nettype wire

// File: design/quaternion_vector_rotate.sv
// Top level: quaternion rotation of a Q2.14 vector with folded normalization
//
//  channel | ports                                     | dir
//  --------+-------------------------------------------+----
//  input   | s_valid s_ready s_quat_w/i/j/k s_vec_x/y/z | in
//  result  | m_valid m_ready m_out_x/y/z m_rotated      | out
//
// An item accepted on s_valid and s_ready passes COMP_WIDTH + 6 stages before it
// shows on m_valid: five front stages, one division cell per quotient bit, and
// the output register. One item enters per cycle while s_ready is high.
// Reset clears only the stage valid bits; data registers hold garbage.
// Each stage advances when it is empty or the next one advances, so a stall
// on m_ready fills bubbles before s_ready drops.
`default_nettype none
module quaternion_vector_rotate #(
    parameter int COMP_WIDTH = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  signed [COMP_WIDTH-1:0] s_quat_w,
    input  wire  signed [COMP_WIDTH-1:0] s_quat_i,
    input  wire  signed [COMP_WIDTH-1:0] s_quat_j,
    input  wire  signed [COMP_WIDTH-1:0] s_quat_k,
    input  wire  signed [COMP_WIDTH-1:0] s_vec_x,
    input  wire  signed [COMP_WIDTH-1:0] s_vec_y,
    input  wire  signed [COMP_WIDTH-1:0] s_vec_z,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic signed [COMP_WIDTH-1:0] m_out_x,
    output logic signed [COMP_WIDTH-1:0] m_out_y,
    output logic signed [COMP_WIDTH-1:0] m_out_z,
    output logic                         m_rotated
);
    localparam int W  = COMP_WIDTH;
    localparam int RW = 3 * W + 7;
    localparam int DW = 2 * W + 2;
    localparam int S  = W + 6;

    // Stage valid bits and the advance chain
    logic [S-1:0] vld_reg;
    logic [S-1:0] en;

    always_comb begin
        en[S-1] = !vld_reg[S-1] || m_ready;
        for (int k = S - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < S; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[S-1];

    // Front pipeline
    logic [2:0][RW-1:0]              f_rem;
    qvr_pkg::qvr_ctl_t [2:0]         f_ctl;
    logic [DW-1:0]                   f_den;
    logic                            f_pass;
    logic [2:0][W-1:0]               f_vec;

    qvr_front #(.W(W)) u_front (
        .aclk   (aclk),
        .en     (en[4:0]),
        .quat_w (s_quat_w),
        .quat_i (s_quat_i),
        .quat_j (s_quat_j),
        .quat_k (s_quat_k),
        .vec_x  (s_vec_x),
        .vec_y  (s_vec_y),
        .vec_z  (s_vec_z),
        .rem_o  (f_rem),
        .ctl_o  (f_ctl),
        .den_o  (f_den),
        .pass_o (f_pass),
        .vec_o  (f_vec)
    );

    // Division chains, one per lane, one cell per quotient bit
    logic [RW-1:0]     c_rem [3][W+1];
    logic [DW-1:0]     c_den [3][W+1];
    logic [W-1:0]      c_quo [3][W+1];
    qvr_pkg::qvr_ctl_t c_ctl [3][W+1];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign c_rem[l][0] = f_rem[l];
        assign c_den[l][0] = f_den;
        assign c_quo[l][0] = '0;
        assign c_ctl[l][0] = f_ctl[l];
        for (genvar c = 0; c < W; c++) begin : g_cell
            qvr_div_cell #(.W(W), .SHIFT(W - 1 - c)) u_cell (
                .aclk  (aclk),
                .en    (en[5+c]),
                .rem_i (c_rem[l][c]),
                .den_i (c_den[l][c]),
                .quo_i (c_quo[l][c]),
                .ctl_i (c_ctl[l][c]),
                .rem_o (c_rem[l][c+1]),
                .den_o (c_den[l][c+1]),
                .quo_o (c_quo[l][c+1]),
                .ctl_o (c_ctl[l][c+1])
            );
        end
    end

    // Carry pass flag and original vector alongside the cells
    logic              sb_pass_reg [W];
    logic [2:0][W-1:0] sb_vec_reg  [W];

    always_ff @(posedge aclk) begin
        for (int c = 0; c < W; c++) begin
            if (en[5+c]) begin
                sb_pass_reg[c] <= (c == 0) ? f_pass : sb_pass_reg[(c == 0) ? 0 : c - 1];
                sb_vec_reg[c]  <= (c == 0) ? f_vec  : sb_vec_reg[(c == 0) ? 0 : c - 1];
            end
        end
    end

    // Clamp, apply sign and pick the pass-through vector
    logic [W:0]         lim [3];
    logic [W:0]         qe  [3];
    logic [W:0]         mv  [3];
    logic [W:0]         sv  [3];
    logic [2:0][W-1:0]  res;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            lim[l] = {2'b00, {(W-1){1'b1}}} + (W+1)'(c_ctl[l][W].neg);
            qe[l]  = {1'b0, c_quo[l][W]};
            mv[l]  = (c_ctl[l][W].sat || qe[l] > lim[l]) ? lim[l] : qe[l];
            sv[l]  = c_ctl[l][W].neg ? -mv[l] : mv[l];
            res[l] = sb_pass_reg[W-1] ? sb_vec_reg[W-1][l] : sv[l][W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[S-1]) begin
            m_out_x   <= res[0];
            m_out_y   <= res[1];
            m_out_z   <= res[2];
            m_rotated <= !sb_pass_reg[W-1];
        end
    end
endmodule
`default_nettype wire

// File: design/qvr_checker.sv
// Port-level checker for the quaternion vector rotation block, with its bind
`default_nettype none
`include "quaternion_vector_rotate_assert.svh"
module qvr_checker #(
    parameter int COMP_WIDTH = 16
) (
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  s_ready,
    input wire                  m_valid,
    input wire                  m_ready,
    input wire [COMP_WIDTH-1:0] m_out_x,
    input wire [COMP_WIDTH-1:0] m_out_y,
    input wire [COMP_WIDTH-1:0] m_out_z,
    input wire                  m_rotated
);
    // Input stalls only when a full pipe is blocked at the output
    `QVR_ASSERT_IMP(a_stall_cause, !s_ready, m_valid && !m_ready)
    // A blocked result holds
    `QVR_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_out_x) && $stable(m_out_y) && $stable(m_out_z) && $stable(m_rotated))
    // Reset empties the pipe
    `QVR_ASSERT_RST(a_reset_empty, !aresetn, !m_valid)
endmodule

bind quaternion_vector_rotate qvr_checker #(.COMP_WIDTH(COMP_WIDTH)) u_qvr_checker (.*);
`default_nettype wire
